// File: src/snva_pkg.sv
// ----------------------------------------------------------------------------
// snva_pkg
// Shared codes for the snapshot versioned array: operation codes, result
// status codes and the sequencer state type.
// ----------------------------------------------------------------------------
package snva_pkg;

  // Operation codes carried in func
  localparam logic [1:0] FUNC_SET  = 2'd0;
  localparam logic [1:0] FUNC_SNAP = 2'd1;
  localparam logic [1:0] FUNC_GET  = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_INDEX  = 3'd1;
  localparam logic [2:0] ST_FULL       = 3'd2;
  localparam logic [2:0] ST_SNAP_LIMIT = 3'd3;
  localparam logic [2:0] ST_NOT_TAKEN  = 3'd4;

  // Sequencer states, one-hot
  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } state_e;

endpackage

// File: src/snapshot_versioned_array.sv
// ----------------------------------------------------------------------------
// snapshot_versioned_array
// Array of 32-bit words with snapshots; each entry keeps a short history of
// (snapshot number, value) slots in one row of a synchronous memory.
// ----------------------------------------------------------------------------
// Usage: every item takes two steps: read the entry's row from the memory
// (registered read), then, held while a stalled result waits, compare the
// slots, write the row back and load the result register. The single row
// memory sets these steps: a set is a read-modify-write of one row. Snap
// items run through the same two steps. A new item is taken while the
// previous result still waits in the output register. After reset the block
// walks the memory once to zero every entry's slot count, one row per cycle,
// and accepts items only after it; configuration writes are taken throughout.
// A set stores under the current snapshot number, overwriting the newest
// slot when it carries that number and appending otherwise (status "versions
// full" when all VERSIONS slots are used). A snap returns the current number
// and advances it, saturating at the top code with status "snap limit". A
// get returns the value of the newest slot whose number is at most the
// asked snapshot, or 0. Set or get indices at or above active_entries or
// ENTRIES give "bad index"; a get of a snapshot not yet taken gives "not taken".
// ----------------------------------------------------------------------------
module snapshot_versioned_array #(
  parameter int ENTRIES   = 1024,
  parameter int VERSIONS  = 8,
  parameter int SNAP_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: active_entries
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i,
  // input items
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [9:0]  entry_index_i,
  input  logic [31:0] write_value_i,
  input  logic [15:0] query_snap_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] result_value_o,
  output logic [2:0]  status_o
);
  import snva_pkg::*;

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(VERSIONS + 1);
  localparam int SW = (VERSIONS > 1) ? $clog2(VERSIONS) : 1;

  // One memory row per entry: slot count, slot snapshot numbers, slot values.
  // Slots below the count hold increasing snapshot numbers.
  typedef struct packed {
    logic [CW-1:0]                    cnt;
    logic [VERSIONS-1:0][SNAP_BITS-1:0] snaps;
    logic [VERSIONS-1:0][31:0]        vals;
  } row_t;

  state_e state_q, state_d;

  logic [10:0]          active_q;
  logic [SNAP_BITS-1:0] snap_q;
  logic [AW-1:0]        clr_q;

  // item held during execution
  logic [1:0]           func_q;
  logic [9:0]           idx_q;
  logic [31:0]          wval_q;
  logic [SNAP_BITS-1:0] qsnap_q;

  // output register
  logic                 out_valid_q;
  logic [31:0]          res_q, res_d;
  logic [2:0]           st_q, st_d;

  // memory
  row_t                 mem [ENTRIES];
  row_t                 rd_q;
  row_t                 wr_row;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [31:0]          in_idx_ext, q_idx_ext, in_q_ext;

  logic                 in_acc;
  logic                 exec_go;
  logic                 idx_ok;
  logic [CW-1:0]        cnt_m1;
  logic [SW-1:0]        last_slot, new_slot;
  logic                 last_match;
  logic                 full;
  logic [VERSIONS-1:0]  hit;
  logic [31:0]          get_val;
  logic                 snap_adv;
  logic                 set_wr;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  // retire only when the output register is free or drains this cycle
  assign exec_go    = (state_q == S_EXEC) && (!out_valid_q || !out_stall_i);

  assign in_idx_ext = 32'(entry_index_i);
  assign q_idx_ext  = 32'(idx_q);
  assign in_q_ext   = 32'(query_snap_i);

  // ---- slot compare and row update ----
  assign idx_ok     = (q_idx_ext < 32'(ENTRIES)) && ({1'b0, idx_q} < active_q);
  assign cnt_m1     = rd_q.cnt - CW'(1);
  assign last_slot  = cnt_m1[SW-1:0];
  assign new_slot   = rd_q.cnt[SW-1:0];
  assign last_match = (rd_q.cnt != '0) && (rd_q.snaps[last_slot] == snap_q);
  assign full       = (32'(rd_q.cnt) >= 32'(VERSIONS));

  always_comb begin
    get_val = '0;
    for (int k = 0; k < VERSIONS; k++) begin
      hit[k] = (32'(k) < 32'(rd_q.cnt)) && (rd_q.snaps[k] <= qsnap_q);
    end
    // newest qualifying slot wins
    for (int k = 0; k < VERSIONS; k++) begin
      if (hit[k]) begin
        get_val = rd_q.vals[k];
      end
    end
  end

  always_comb begin
    res_d    = '0;
    st_d     = ST_OK;
    snap_adv = 1'b0;
    set_wr   = 1'b0;
    wr_row   = rd_q;
    unique case (func_q)
      FUNC_SET: begin
        if (!idx_ok) begin
          st_d = ST_BAD_INDEX;
        end else if (last_match) begin
          set_wr                 = 1'b1;
          wr_row.vals[last_slot] = wval_q;
        end else if (full) begin
          st_d = ST_FULL;
        end else begin
          set_wr                  = 1'b1;
          wr_row.snaps[new_slot]  = snap_q;
          wr_row.vals[new_slot]   = wval_q;
          wr_row.cnt              = rd_q.cnt + CW'(1);
        end
      end
      FUNC_SNAP: begin
        res_d = 32'(snap_q);
        if (snap_q == '1) begin
          st_d = ST_SNAP_LIMIT;
        end else begin
          snap_adv = 1'b1;
        end
      end
      FUNC_GET: begin
        if (!idx_ok) begin
          st_d = ST_BAD_INDEX;
        end else if (qsnap_q >= snap_q) begin
          st_d = ST_NOT_TAKEN;
        end else begin
          res_d = get_val;
        end
      end
      default: begin
        // unused code: no operation
        res_d = '0;
        st_d  = ST_OK;
      end
    endcase
    if (state_q == S_CLEAR) begin
      wr_row = '0;
    end
  end

  assign mem_we    = (state_q == S_CLEAR) || (exec_go && set_wr);
  assign mem_waddr = (state_q == S_CLEAR) ? clr_q : q_idx_ext[AW-1:0];

  // ---- row memory: one write port, one registered read port ----
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= wr_row;
    end
    if (in_acc) begin
      rd_q <= mem[in_idx_ext[AW-1:0]];
    end
  end

  // ---- sequencer ----
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (clr_q == AW'(ENTRIES - 1)) state_d = S_IDLE;
      S_IDLE:  if (in_acc) state_d = S_EXEC;
      S_EXEC:  if (exec_go) state_d = S_IDLE;
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      active_q    <= 11'd1024;
      snap_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cfg_we_i) begin
        active_q <= cfg_wdata_i;
      end
      if (exec_go && snap_adv) begin
        snap_q <= snap_q + SNAP_BITS'(1);
      end
      if (exec_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // capture the item and the result; payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q  <= func_i;
      idx_q   <= entry_index_i;
      wval_q  <= write_value_i;
      qsnap_q <= in_q_ext[SNAP_BITS-1:0];
    end
    if (exec_go) begin
      res_q <= res_d;
      st_q  <= st_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = res_q;
  assign status_o       = st_q;

  // ---- assertions ----
  // Memory writes come only from the clearing walk or from a retiring item.
  a_we_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_CLEAR) || (state_q == S_EXEC))
    else $error("row write outside clear or execute");

  // The snapshot counter moves only after a retiring snap.
  a_snap_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(snap_q) |-> $past(exec_go && (func_q == FUNC_SNAP)))
    else $error("snapshot counter changed without a snap");

  // A new result appears only right after an item retires.
  a_out_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_EXEC))
    else $error("result valid without a retiring item");

endmodule

// File: tb/snva_tb_pkg.sv
// ----------------------------------------------------------------------------
// snva_tb_pkg
// Scoreboard for the snapshot versioned array: keeps its own copy of the
// snapshot counter, slot counts and slots, predicts one result per item and
// compares the results that come back in order.
// ----------------------------------------------------------------------------
package snva_tb_pkg;

  import snva_pkg::*;

  localparam int TB_ENTRIES  = 1024;
  localparam int TB_VERSIONS = 8;

  typedef struct packed {
    logic [31:0] value;
    logic [2:0]  status;
  } snva_result_t;

  class snva_scoreboard;
    logic [10:0]  active_entries;
    logic [15:0]  snap_ctr;
    logic [3:0]   slot_count [TB_ENTRIES];
    logic [15:0]  slot_snap  [TB_ENTRIES*TB_VERSIONS];
    logic [31:0]  slot_value [TB_ENTRIES*TB_VERSIONS];
    snva_result_t awaited_results [$];
    int           mismatches;

    function new();
      active_entries = 11'd1024;
      snap_ctr       = '0;
      mismatches     = 0;
      foreach (slot_count[i]) slot_count[i] = '0;
    endfunction

    function void set_active(logic [10:0] n);
      active_entries = n;
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction

    // Apply one accepted item to the shadow state and queue its result.
    function void note_request(logic [1:0] func, logic [9:0] idx,
                               logic [31:0] wval, logic [15:0] q);
      snva_result_t res;
      int           base;
      int           cnt;
      int           k;
      bit           idx_ok;
      res.value  = '0;
      res.status = ST_OK;
      idx_ok     = ({1'b0, idx} < active_entries);
      base       = int'(idx) * TB_VERSIONS;
      cnt        = int'(slot_count[idx]);
      case (func)
        FUNC_SET: begin
          if (!idx_ok) begin
            res.status = ST_BAD_INDEX;
          end else if (cnt > 0 && slot_snap[base+cnt-1] == snap_ctr) begin
            slot_value[base+cnt-1] = wval;
          end else if (cnt >= TB_VERSIONS) begin
            res.status = ST_FULL;
          end else begin
            slot_snap[base+cnt]  = snap_ctr;
            slot_value[base+cnt] = wval;
            slot_count[idx]      = 4'(cnt + 1);
          end
        end
        FUNC_SNAP: begin
          res.value = {16'd0, snap_ctr};
          if (snap_ctr == '1) res.status = ST_SNAP_LIMIT;
          else snap_ctr = snap_ctr + 16'd1;
        end
        FUNC_GET: begin
          if (!idx_ok) begin
            res.status = ST_BAD_INDEX;
          end else if (q >= snap_ctr) begin
            res.status = ST_NOT_TAKEN;
          end else begin
            // walk back from the newest slot to the first one not after q
            k = cnt;
            while (k > 0 && slot_snap[base+k-1] > q) k--;
            if (k > 0) res.value = slot_value[base+k-1];
          end
        end
        default: ;
      endcase
      awaited_results.push_back(res);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("mismatch: %s", msg);
    endtask

    task check_result(logic [31:0] value, logic [2:0] status);
      snva_result_t want;
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result value=%h status=%0d", value, status));
        return;
      end
      want = awaited_results.pop_front();
      if (value !== want.value)
        report_mismatch($sformatf("result_value %h, want %h", value, want.value));
      if (status !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", status, want.status));
    endtask
  endclass

endpackage

// File: tb/snapshot_versioned_array_tb.sv
// ----------------------------------------------------------------------------
// snapshot_versioned_array_tb
// Self-checking bench for the snapshot versioned array. Drives set, snap and
// get items with random gaps and output stalls, predicts every result in a
// scoreboard and checks them in order, across several active_entries values.
// ----------------------------------------------------------------------------
module snapshot_versioned_array_tb;

  import snva_pkg::*;
  import snva_tb_pkg::*;

  // func code 3 does nothing; the block answers 0 / ok
  localparam logic [1:0] FUNC_NOP = 2'd3;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int HOLD_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [10:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  func = '0;
  logic [9:0]  entry_index = '0;
  logic [31:0] write_value = '0;
  logic [15:0] query_snap = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] result_value;
  logic [2:0]  status;

  snva_scoreboard sb;

  int tx_gap_max = 17;
  int rx_gap_max = 17;
  int rx_wait = 0;
  bit rx_block = 1'b0;
  bit pressure_req = 1'b0;
  int cycle_cnt = 0;

  snapshot_versioned_array DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .func_i         (func),
    .entry_index_i  (entry_index),
    .write_value_i  (write_value),
    .query_snap_i   (query_snap),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .result_value_o (result_value),
    .status_o       (status)
  );

  always #5 clk = ~clk;

  // Receiver: after each result, hold stall for a random number of cycles.
  // rx_wait and rx_block change at the rising edge and are read here at the
  // falling edge, so the two processes never race.
  always @(negedge clk) begin
    if (rx_block) begin
      out_stall = 1'b1;
    end else if (rx_wait > 0) begin
      out_stall = 1'b1;
      rx_wait--;
    end else begin
      out_stall = 1'b0;
    end
  end

  // Monitor: take a result at each edge where it is valid and not stalled.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      sb.check_result(result_value, status);
      rx_wait = $urandom_range(0, rx_gap_max);
    end
  end

  // Long hold-off of the receiver, once, so the block backs up into its input.
  initial begin
    wait (pressure_req);
    @(posedge clk);
    rx_block = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_block = 1'b0;
  end

  // Watchdog: end the run if it hangs.
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("** snapshot_versioned_array: FAILED **");
    $finish;
  end

  // Offer one item after a random gap and hold it until it is taken.
  // Entered and left at a falling edge; valid stays high between
  // back-to-back items.
  task automatic send_item(logic [1:0] f, logic [9:0] idx, logic [31:0] wval,
                           logic [15:0] q);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    func        = f;
    entry_index = idx;
    write_value = wval;
    query_snap  = q;
    in_valid    = 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_request(f, idx, wval, q);
    @(negedge clk);
  endtask

  // Random items, mostly on a few hot entries so their slots fill up, with
  // some indices over the whole field and some snapshot queries far ahead.
  task automatic send_random(int n, bit burst);
    int         span;
    int         hot;
    int         pick;
    logic [1:0] f;
    logic [9:0] idx;
    logic [15:0] q;
    for (int i = 0; i < n; i++) begin
      // switch pacing now and then, including runs with no idling at all
      if (i % 20 == 0) begin
        tx_gap_max = (burst || $urandom_range(0, 3) == 0) ? 0 : 17;
        rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 17;
      end
      span = (sb.active_entries == 0) ? 1 :
             (sb.active_entries > 1024) ? 1024 : int'(sb.active_entries);
      hot  = (span < 4) ? span : 4;
      pick = $urandom_range(0, 99);
      f = (pick < 45) ? FUNC_SET : (pick < 60) ? FUNC_SNAP :
          (pick < 95) ? FUNC_GET : FUNC_NOP;
      pick = $urandom_range(0, 9);
      if (pick < 6) idx = 10'($urandom_range(0, hot - 1));
      else if (pick < 8) idx = 10'($urandom_range(0, span - 1));
      else if (pick == 8) idx = 10'(span);
      else idx = 10'($urandom);
      if ($urandom_range(0, 9) < 7) q = 16'($urandom_range(0, int'(sb.snap_ctr)));
      else q = 16'($urandom);
      send_item(f, idx, $urandom, q);
    end
  endtask

  // Drop valid and wait until every result is back and the block is quiet.
  task automatic settle();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_active(logic [10:0] n);
    cfg_we    = 1'b1;
    cfg_wdata = n;
    @(negedge clk);
    cfg_we    = 1'b0;
    sb.set_active(n);
  endtask

  initial begin
    sb = new();
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    write_active(11'd1024);

    // Directed: empty history, overwrite, field extremes, unused func,
    // versions full and a lookup into an older snapshot.
    send_item(FUNC_GET, 10'd0, 32'd0, 16'd0);                 // not taken yet
    send_item(FUNC_SET, 10'd0, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(FUNC_SET, 10'd0, 32'h1234_5678, 16'd0);         // overwrite
    send_item(FUNC_SET, 10'd1023, 32'd0, 16'd0);
    send_item(FUNC_SNAP, 10'd0, 32'd0, 16'd0);
    send_item(FUNC_GET, 10'd0, 32'd0, 16'd0);
    send_item(FUNC_GET, 10'd3, 32'd0, 16'd0);                 // no slot, 0
    send_item(FUNC_GET, 10'd0, 32'd0, 16'hFFFF);              // not taken
    send_item(FUNC_NOP, 10'd1023, 32'hFFFF_FFFF, 16'hFFFF);
    for (int i = 0; i < 7; i++) begin
      send_item(FUNC_SET, 10'd0, $urandom, 16'd0);
      send_item(FUNC_SNAP, 10'd0, 32'd0, 16'd0);
    end
    send_item(FUNC_SET, 10'd0, 32'hA5A5_A5A5, 16'd0);         // versions full
    send_item(FUNC_GET, 10'd0, 32'd0, 16'd3);
    send_random(100, 1'b0);
    settle();

    // Smallest nonempty active range: only entry 0 is valid, index checked first.
    write_active(11'd1);
    send_item(FUNC_SET, 10'd1, 32'h5555_AAAA, 16'd0);
    send_item(FUNC_GET, 10'd1023, 32'd0, 16'd0);
    send_item(FUNC_GET, 10'd1, 32'd0, 16'hFFFF);
    send_random(60, 1'b0);
    settle();

    // Zero active entries: every set and get is a bad index.
    write_active(11'd0);
    send_random(30, 1'b0);
    settle();

    // Top of the register field: ENTRIES bounds the index.
    write_active(11'd2047);
    send_random(60, 1'b0);
    settle();

    // Mid range, with the long receiver hold-off while the sender pushes.
    write_active(11'd37);
    pressure_req = 1'b1;
    send_random(40, 1'b1);
    send_random(60, 1'b0);
    settle();

    write_active(11'd1024);
    send_random(50, 1'b0);

    // Close with a run without sender gaps: a set and snaps, then queries of
    // snapshots not taken yet, with sets between them.
    tx_gap_max = 0;
    rx_gap_max = 0;
    send_item(FUNC_SET, 10'd2, 32'hDEAD_BEEF, 16'd0);
    send_item(FUNC_SNAP, 10'd0, 32'd0, 16'd0);
    send_item(FUNC_SNAP, 10'd0, 32'd0, 16'd0);
    send_item(FUNC_GET, 10'd2, 32'd0, 16'hFFFE);
    send_item(FUNC_GET, 10'd2, 32'd0, 16'hFFFF);              // never taken
    send_item(FUNC_SET, 10'd0, 32'hFFFF_FFFF, 16'd0);
    send_item(FUNC_SET, 10'd1, 32'h0000_0001, 16'd0);
    send_item(FUNC_GET, 10'd1, 32'd0, 16'hFFFE);
    settle();

    repeat (10) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("** snapshot_versioned_array: PASSED **");
    end else begin
      $display("** snapshot_versioned_array: FAILED **");
    end
    $finish;
  end

endmodule
